[rtl/core/vpfn_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpfn_pkg
// Types, codes and constants shared by the point fit normalizer modules.
// ---------------------------------------------------------------------------
package vpfn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAP_SHIFT = 24 - FRAC_BITS;
    localparam int OFF_SHIFT = MAP_SHIFT + 1;
    localparam int DIV_LAST  = 46;

    localparam logic signed [63:0] ONE_FIX  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] SAT_LIM  = 64'sd1099511627776;
    localparam logic signed [63:0] POS_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] NEG_MIN  = -64'sd2147483648;
    localparam logic [15:0]        COEFF_97 = 16'd63570;
    localparam logic [56:0]        ROUND_HALF = 57'd32768;

    localparam logic [1:0] CMD_CLEAR     = 2'd0;
    localparam logic [1:0] CMD_MEASURE   = 2'd1;
    localparam logic [1:0] CMD_TRANSFORM = 2'd2;

    localparam logic [1:0] ST_ACK   = 2'd0;
    localparam logic [1:0] ST_POINT = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_MAX   = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;
    localparam logic [1:0] MODE_DEV   = 2'd3;

    localparam logic [2:0] REG_FIT_MODE   = 3'd0;
    localparam logic [2:0] REG_IMG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_IMG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_USE_FIXED  = 3'd3;
    localparam logic [2:0] REG_FIX_MIN_X  = 3'd4;
    localparam logic [2:0] REG_FIX_MAX_X  = 3'd5;
    localparam logic [2:0] REG_FIX_MIN_Y  = 3'd6;
    localparam logic [2:0] REG_FIX_MAX_Y  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_DIV,
        S_OFF_LOAD,
        S_MUL_HI,
        S_MUL_LO,
        S_MUL_SUM,
        S_OFF_FIN,
        S_AX_LOAD,
        S_AX_FIN,
        S_AX_SCL,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_PICK,
        OP_DIV_STEP,
        OP_OFF_LOAD,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_MUL_SUM,
        OP_OFF_FIN,
        OP_AX_LOAD,
        OP_AX_FIN,
        OP_AX_SCL,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis_y;
    } dp_cmd_t;

    typedef struct packed {
        logic pick_fail;
        logic div_done;
        logic dev_mode;
        logic fit_ready;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > POS_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < NEG_MIN)
            r = -32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/core/vpfn_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpfn_in_if / vpfn_out_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface vpfn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (output valid, output command, output point_x, output point_y,
                    input ready);
    modport sink (input valid, input command, input point_x, input point_y,
                  output ready);
endinterface

interface vpfn_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;

    modport source (output valid, output status, output out_x, output out_y,
                    input ready);
    modport sink (input valid, input status, input out_x, input out_y,
                  output ready);
endinterface

[rtl/core/vpfn_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpfn_datapath
// Registers, bounding box, reciprocal divider, shared multiplier and output.
// ---------------------------------------------------------------------------
module vpfn_datapath
    import vpfn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         sts,
    input  logic [1:0]         command,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic [1:0]         status,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);

    logic [1:0]         fit_mode_reg;
    logic [30:0]        image_width_reg;
    logic [30:0]        image_height_reg;
    logic               use_fixed_reg;
    logic signed [31:0] fixed_min_x_reg;
    logic signed [31:0] fixed_max_x_reg;
    logic signed [31:0] fixed_min_y_reg;
    logic signed [31:0] fixed_max_y_reg;

    logic signed [31:0] box_min_x_reg;
    logic signed [31:0] box_max_x_reg;
    logic signed [31:0] box_min_y_reg;
    logic signed [31:0] box_max_y_reg;
    logic               box_has_point_reg;
    logic               fit_ready_reg;
    logic [46:0]        ratio_mag_reg;
    logic               ratio_neg_reg;
    logic signed [31:0] offset_x_reg;
    logic signed [31:0] offset_y_reg;
    logic [1:0]         eff_mode_reg;

    logic signed [31:0] item_x_reg;
    logic signed [31:0] item_y_reg;
    logic [1:0]         mode_pend_reg;
    logic [32:0]        la_reg;
    logic               wide_reg;
    logic signed [33:0] small_reg;
    logic [33:0]        rem_reg;
    logic [5:0]         div_cnt_reg;
    logic [33:0]        va_reg;
    logic               neg_reg;
    logic signed [33:0] vd_reg;
    logic [57:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic signed [41:0] vc_reg;
    logic [1:0]         res_status_reg;
    logic signed [31:0] res_x_reg;
    logic signed [31:0] res_y_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;

    // settle selection
    logic signed [32:0] mnx, mxx, mny, mxy, iw_s, ih_s;
    logic signed [33:0] w, h, big, la_full, sm_side;
    logic [1:0]         mode_p;
    logic               pick_fail;

    always_comb
    begin
        iw_s = $signed({2'b00, image_width_reg});
        ih_s = $signed({2'b00, image_height_reg});
        if (use_fixed_reg)
        begin
            mnx = 33'(fixed_min_x_reg);
            mxx = 33'(fixed_max_x_reg);
            mny = 33'(fixed_min_y_reg);
            mxy = 33'(fixed_max_y_reg);
        end
        else
        begin
            mnx = 33'(box_min_x_reg);
            mxx = 33'(box_max_x_reg);
            mny = 33'(box_min_y_reg);
            mxy = 33'(box_max_y_reg);
        end
        mode_p = fit_mode_reg;
        if (mode_p == MODE_FRAME &&
            (mnx < 0 || mny < 0 || mxx > iw_s || mxy > ih_s ||
             image_width_reg == '0 || image_height_reg == '0))
            mode_p = MODE_MAX;
        if ((mode_p == MODE_FRAME || mode_p == MODE_DEV) && !use_fixed_reg)
        begin
            mnx = '0;
            mxx = iw_s;
            mny = '0;
            mxy = ih_s;
        end
        w         = 34'(mxx) - 34'(mnx);
        h         = 34'(mxy) - 34'(mny);
        big       = (w > h) ? w : h;
        sm_side   = (w > h) ? h : w;
        la_full   = big[33] ? -big : big;
        pick_fail = (!use_fixed_reg && !box_has_point_reg) || w == '0 || h == '0;
    end

    // multiplier and result shaping
    logic [23:0]        seg;
    logic [57:0]        prod;
    logic [63:0]        m_map, m_off;
    logic signed [63:0] sm_map, sm_off, off_val, base, vflip;
    logic signed [41:0] vc_next;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic signed [31:0] org;
    logic signed [33:0] vd_next;
    logic [40:0]        mag97;
    logic [56:0]        p97;
    logic signed [63:0] s97;
    logic signed [31:0] ax_res;

    always_comb
    begin
        seg    = (cmd.op == OP_MUL_HI) ? {1'b0, ratio_mag_reg[46:24]} : ratio_mag_reg[23:0];
        prod   = 58'(va_reg) * 58'(seg);
        m_map  = acc_reg >> MAP_SHIFT;
        m_off  = acc_reg >> OFF_SHIFT;
        sm_map = neg_reg ? -$signed(m_map) : $signed(m_map);
        sm_off = neg_reg ? -$signed(m_off) : $signed(m_off);
        off_val = ONE_FIX - sm_off;

        rem_sh = {rem_reg[32:0], (div_cnt_reg == 6'(DIV_LAST))};
        rem_ge = rem_sh >= {1'b0, la_reg};

        if (use_fixed_reg)
            org = cmd.axis_y ? fixed_min_y_reg : fixed_min_x_reg;
        else if (eff_mode_reg == MODE_FRAME || eff_mode_reg == MODE_DEV)
            org = '0;
        else
            org = cmd.axis_y ? box_min_y_reg : box_min_x_reg;
        vd_next = 34'(cmd.axis_y ? item_y_reg : item_x_reg) - 34'(org);

        if (eff_mode_reg == MODE_DEV)
            base = 64'(vd_reg);
        else
            base = sm_map - ONE_FIX + 64'(cmd.axis_y ? offset_y_reg : offset_x_reg);
        vflip = cmd.axis_y ? -base : base;
        if (vflip > SAT_LIM)
            vc_next = 42'(SAT_LIM);
        else if (vflip < -SAT_LIM)
            vc_next = 42'(-SAT_LIM);
        else
            vc_next = vflip[41:0];

        mag97 = vc_reg[41] ? 41'(-vc_reg) : vc_reg[40:0];
        p97   = (57'(mag97) * 57'(COEFF_97) + ROUND_HALF) >> 16;
        s97   = vc_reg[41] ? -$signed({7'b0, p97}) : $signed({7'b0, p97});
        ax_res = (eff_mode_reg == MODE_MAX) ? sat32(s97) : sat32(64'(vc_reg));
    end

    assign sts.pick_fail = pick_fail;
    assign sts.div_done  = (div_cnt_reg == '0);
    assign sts.dev_mode  = (eff_mode_reg == MODE_DEV);
    assign sts.fit_ready = fit_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg      <= '0;
            image_width_reg   <= '0;
            image_height_reg  <= '0;
            use_fixed_reg     <= 1'b0;
            fixed_min_x_reg   <= '0;
            fixed_max_x_reg   <= '0;
            fixed_min_y_reg   <= '0;
            fixed_max_y_reg   <= '0;
            box_min_x_reg     <= '0;
            box_max_x_reg     <= '0;
            box_min_y_reg     <= '0;
            box_max_y_reg     <= '0;
            box_has_point_reg <= 1'b0;
            fit_ready_reg     <= 1'b0;
            ratio_mag_reg     <= '0;
            ratio_neg_reg     <= 1'b0;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            eff_mode_reg      <= '0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_ACCEPT:
                begin
                    if (command == CMD_CLEAR)
                    begin
                        box_min_x_reg     <= '0;
                        box_max_x_reg     <= '0;
                        box_min_y_reg     <= '0;
                        box_max_y_reg     <= '0;
                        box_has_point_reg <= 1'b0;
                        fit_ready_reg     <= 1'b0;
                    end
                    else if (command == CMD_MEASURE)
                    begin
                        if (!box_has_point_reg || point_x < box_min_x_reg)
                            box_min_x_reg <= point_x;
                        if (!box_has_point_reg || point_x > box_max_x_reg)
                            box_max_x_reg <= point_x;
                        if (!box_has_point_reg || point_y < box_min_y_reg)
                            box_min_y_reg <= point_y;
                        if (!box_has_point_reg || point_y > box_max_y_reg)
                            box_max_y_reg <= point_y;
                        box_has_point_reg <= 1'b1;
                        fit_ready_reg     <= 1'b0;
                    end
                end
                OP_PICK:
                begin
                    ratio_mag_reg <= '0;
                    ratio_neg_reg <= big[33];
                    div_cnt_reg   <= 6'(DIV_LAST);
                end
                OP_DIV_STEP:
                begin
                    ratio_mag_reg <= {ratio_mag_reg[45:0], rem_ge};
                    div_cnt_reg   <= div_cnt_reg - 6'd1;
                end
                OP_OFF_FIN:
                begin
                    offset_x_reg  <= wide_reg ? 32'sd0 : sat32(off_val);
                    offset_y_reg  <= wide_reg ? sat32(off_val) : 32'sd0;
                    eff_mode_reg  <= mode_pend_reg;
                    fit_ready_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase

            if (cfg_we)
            begin
                fit_ready_reg <= 1'b0;
                case (cfg_index)
                    REG_FIT_MODE:   fit_mode_reg     <= cfg_data[1:0];
                    REG_IMG_WIDTH:  image_width_reg  <= cfg_data[30:0];
                    REG_IMG_HEIGHT: image_height_reg <= cfg_data[30:0];
                    REG_USE_FIXED:  use_fixed_reg    <= cfg_data[0];
                    REG_FIX_MIN_X:  fixed_min_x_reg  <= cfg_data;
                    REG_FIX_MAX_X:  fixed_max_x_reg  <= cfg_data;
                    REG_FIX_MIN_Y:  fixed_min_y_reg  <= cfg_data;
                    REG_FIX_MAX_Y:  fixed_max_y_reg  <= cfg_data;
                    default:        fit_mode_reg     <= fit_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                item_x_reg     <= point_x;
                item_y_reg     <= point_y;
                res_status_reg <= ST_ACK;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            OP_PICK:
            begin
                mode_pend_reg <= mode_p;
                la_reg        <= la_full[32:0];
                wide_reg      <= (w > h);
                small_reg     <= sm_side;
                rem_reg       <= '0;
                if (pick_fail)
                begin
                    res_status_reg <= ST_DEGEN;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                end
            end
            OP_DIV_STEP:
                rem_reg <= rem_ge ? rem_sh - {1'b0, la_reg} : rem_sh;
            OP_OFF_LOAD:
            begin
                va_reg  <= small_reg[33] ? 34'(-small_reg) : small_reg;
                neg_reg <= small_reg[33] ^ ratio_neg_reg;
            end
            OP_AX_LOAD:
            begin
                vd_reg  <= vd_next;
                va_reg  <= vd_next[33] ? 34'(-vd_next) : vd_next;
                neg_reg <= vd_next[33] ^ ratio_neg_reg;
            end
            OP_MUL_HI:
                prod_reg <= prod;
            OP_MUL_LO:
            begin
                prod_reg <= prod;
                acc_reg  <= {3'b000, prod_reg, 3'b000};
            end
            OP_MUL_SUM:
                acc_reg <= acc_reg + 64'(prod_reg >> 21);
            OP_AX_FIN:
                vc_reg <= vc_next;
            OP_AX_SCL:
            begin
                if (cmd.axis_y)
                begin
                    res_y_reg      <= ax_res;
                    res_status_reg <= ST_POINT;
                end
                else
                    res_x_reg <= ax_res;
            end
            OP_LOAD_OUT:
            begin
                out_status_reg <= res_status_reg;
                out_x_reg      <= res_x_reg;
                out_y_reg      <= res_y_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status = out_status_reg;
    assign out_x  = out_x_reg;
    assign out_y  = out_y_reg;

endmodule

[rtl/core/vpfn_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vpfn_ctrl
// Sequencer for accept, settle, per-axis mapping and result hand-off.
// ---------------------------------------------------------------------------
module vpfn_ctrl
    import vpfn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_command,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   tgt_off_reg, tgt_off_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        tgt_off_next = tgt_off_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    axis_next = 1'b0;
                    if (in_command == CMD_TRANSFORM)
                        state_next = sts.fit_ready ? S_AX_LOAD : S_PICK;
                    else
                        state_next = S_OUT;
                end
            S_PICK:     state_next = sts.pick_fail ? S_OUT : S_DIV;
            S_DIV:      state_next = sts.div_done ? S_OFF_LOAD : S_DIV;
            S_OFF_LOAD:
            begin
                tgt_off_next = 1'b1;
                state_next   = S_MUL_HI;
            end
            S_MUL_HI:   state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_SUM;
            S_MUL_SUM:  state_next = tgt_off_reg ? S_OFF_FIN : S_AX_FIN;
            S_OFF_FIN:
            begin
                axis_next  = 1'b0;
                state_next = S_AX_LOAD;
            end
            S_AX_LOAD:
            begin
                tgt_off_next = 1'b0;
                state_next   = sts.dev_mode ? S_AX_FIN : S_MUL_HI;
            end
            S_AX_FIN:   state_next = S_AX_SCL;
            S_AX_SCL:
            begin
                axis_next  = 1'b1;
                state_next = axis_reg ? S_OUT : S_AX_LOAD;
            end
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.axis_y = axis_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_ACCEPT : OP_NONE;
            end
            S_PICK:     cmd.op = OP_PICK;
            S_DIV:      cmd.op = OP_DIV_STEP;
            S_OFF_LOAD: cmd.op = OP_OFF_LOAD;
            S_MUL_HI:   cmd.op = OP_MUL_HI;
            S_MUL_LO:   cmd.op = OP_MUL_LO;
            S_MUL_SUM:  cmd.op = OP_MUL_SUM;
            S_OFF_FIN:  cmd.op = OP_OFF_FIN;
            S_AX_LOAD:  cmd.op = OP_AX_LOAD;
            S_AX_FIN:   cmd.op = OP_AX_FIN;
            S_AX_SCL:   cmd.op = OP_AX_SCL;
            S_OUT:      cmd.op = out_free ? OP_LOAD_OUT : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_LOAD_OUT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            tgt_off_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            tgt_off_reg   <= tgt_off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && sts.div_done) |=> state_reg == S_OFF_LOAD)
        else $error("divider exit missed");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD_OUT |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_LOAD_OUT))
        else $error("result shown without load");

    a_settle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_command == CMD_TRANSFORM && !sts.fit_ready)
        |=> state_reg == S_PICK)
        else $error("unsettled transform skipped settle");
`endif

endmodule

[rtl/core/vector_point_fit_normalizer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_point_fit_normalizer
// Fits Q16.16 points into the [-1, 1] square from a measured or fixed box.
// ---------------------------------------------------------------------------
// One item is processed at a time. Clear and measure go from acceptance
// to the result register. A transform on a settled fit takes each axis
// through a subtract, a split 34x24 multiply (high part, low part, sum)
// against the stored reciprocal, a finish and an optional 0.97 scale; dev
// mode skips the multiply. The first transform after a clear, a measure or
// a register write settles the fit first, mainly in the 47-step restoring
// divider forming the reciprocal of the larger side. The result register
// lets the next transaction be accepted while a result waits to be taken.
module vector_point_fit_normalizer
    import vpfn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vpfn_in_if.sink     in_ch,
    vpfn_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    vpfn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    vpfn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .command   (in_ch.command),
        .point_x   (in_ch.point_x),
        .point_y   (in_ch.point_y),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (out_ch.status),
        .out_x     (out_ch.out_x),
        .out_y     (out_ch.out_y)
    );

endmodule

[bench/vector_point_fit_normalizer_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_point_fit_normalizer_test
// Drives clear, measure and transform transactions through the fit
// normaliser under random idling, stalls and register settings. A local fit
// model forms the expected status and coordinates of every transaction, and
// each result is compared field by field in order of arrival.
// ---------------------------------------------------------------------------
module vector_point_fit_normalizer_test;
    import vpfn_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } fit_result_t;

    class fit_scoreboard;
        logic [1:0] mode;
        longint     img_w, img_h;
        bit         fixed;
        longint     fix_mnx, fix_mxx, fix_mny, fix_mxy;
        longint     box_mnx, box_mxx, box_mny, box_mxy;
        bit         has_point, settled;
        longint     ratio, off_x, off_y;
        logic [1:0] eff_mode;
        fit_result_t pending[$];
        int         errors;

        function new();
            mode = MODE_PLAIN; img_w = 0; img_h = 0; fixed = 0;
            fix_mnx = 0; fix_mxx = 0; fix_mny = 0; fix_mxy = 0;
            box_mnx = 0; box_mxx = 0; box_mny = 0; box_mxy = 0;
            has_point = 0; settled = 0; ratio = 0; off_x = 0; off_y = 0;
            eff_mode = MODE_PLAIN; errors = 0;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint ratio_product(longint v, longint r, int extra);
            bit [63:0] va, ra, a, b, m;
            bit neg;
            va = (v < 0) ? -v : v;
            ra = (r < 0) ? -r : r;
            neg = (v < 0) != (r < 0);
            a = va * (ra >> 24);
            b = va * (ra & 64'hFF_FFFF);
            m = ((a << 3) + (b >> 21)) >> (24 - FRAC_BITS + extra);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint shrink97(longint v);
            bit [63:0] m;
            longint c;
            c = v;
            if (c > SAT_LIM)
                c = SAT_LIM;
            if (c < -SAT_LIM)
                c = -SAT_LIM;
            m = ((c < 0 ? -c : c) * 64'd63570 + 64'd32768) >> 16;
            return (c < 0) ? -longint'(m) : longint'(m);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_FIT_MODE:   mode = d[1:0];
                REG_IMG_WIDTH:  img_w = longint'({1'b0, d[30:0]});
                REG_IMG_HEIGHT: img_h = longint'({1'b0, d[30:0]});
                REG_USE_FIXED:  fixed = d[0];
                REG_FIX_MIN_X:  fix_mnx = longint'(signed'(d));
                REG_FIX_MAX_X:  fix_mxx = longint'(signed'(d));
                REG_FIX_MIN_Y:  fix_mny = longint'(signed'(d));
                REG_FIX_MAX_Y:  fix_mxy = longint'(signed'(d));
                default: ;
            endcase
            settled = 0;
        endfunction

        function bit settle();
            longint mnx, mxx, mny, mxy, w, h, l, la;
            logic [1:0] m;
            m = mode;
            if (fixed)
            begin
                mnx = fix_mnx; mxx = fix_mxx; mny = fix_mny; mxy = fix_mxy;
            end
            else if (has_point)
            begin
                mnx = box_mnx; mxx = box_mxx; mny = box_mny; mxy = box_mxy;
            end
            else
                return 0;
            if (m == MODE_FRAME && (mnx < 0 || mny < 0 || mxx > img_w || mxy > img_h
                                    || img_w == 0 || img_h == 0))
                m = MODE_MAX;
            if ((m == MODE_FRAME || m == MODE_DEV) && !fixed)
            begin
                mnx = 0; mxx = img_w; mny = 0; mxy = img_h;
            end
            w = mxx - mnx;
            h = mxy - mny;
            if (w == 0 || h == 0)
                return 0;
            l = (w > h) ? w : h;
            la = (l < 0) ? -l : l;
            ratio = longint'((64'd1 << 46) / unsigned'(la));
            if (l < 0)
                ratio = -ratio;
            if (w > h)
            begin
                off_x = 0;
                off_y = clip32((64'sd1 <<< FRAC_BITS) - ratio_product(h, ratio, 1));
            end
            else
            begin
                off_y = 0;
                off_x = clip32((64'sd1 <<< FRAC_BITS) - ratio_product(w, ratio, 1));
            end
            eff_mode = m;
            settled = 1;
            return 1;
        endfunction

        function longint map_axis(longint p, longint origin, longint off, bit flip);
            longint v;
            v = p - origin;
            if (eff_mode != MODE_DEV)
                v = ratio_product(v, ratio, 0) - (64'sd1 <<< FRAC_BITS) + off;
            if (flip)
                v = -v;
            if (eff_mode == MODE_MAX)
                v = shrink97(v);
            return clip32(v);
        endfunction

        function void note(logic [1:0] c, logic signed [31:0] px, logic signed [31:0] py);
            fit_result_t r;
            longint x, y, ox, oy;
            x = px;
            y = py;
            r.status = ST_ACK; r.x = 0; r.y = 0;
            if (c == CMD_CLEAR)
            begin
                box_mnx = 0; box_mxx = 0; box_mny = 0; box_mxy = 0;
                has_point = 0; settled = 0;
            end
            else if (c == CMD_MEASURE)
            begin
                if (!has_point)
                begin
                    box_mnx = x; box_mxx = x; box_mny = y; box_mxy = y;
                    has_point = 1;
                end
                else
                begin
                    if (x < box_mnx) box_mnx = x;
                    if (x > box_mxx) box_mxx = x;
                    if (y < box_mny) box_mny = y;
                    if (y > box_mxy) box_mxy = y;
                end
                settled = 0;
            end
            else if (c == CMD_TRANSFORM)
            begin
                if (!settled && !settle())
                    r.status = ST_DEGEN;
                else
                begin
                    if ((eff_mode == MODE_FRAME || eff_mode == MODE_DEV) && !fixed)
                    begin
                        ox = 0; oy = 0;
                    end
                    else if (fixed)
                    begin
                        ox = fix_mnx; oy = fix_mny;
                    end
                    else
                    begin
                        ox = box_mnx; oy = box_mny;
                    end
                    r.status = ST_POINT;
                    r.x = 32'(map_axis(x, ox, off_x, 0));
                    r.y = 32'(map_axis(y, oy, off_y, 1));
                end
            end
            pending = {pending, r};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check(logic [1:0] st, logic signed [31:0] x, logic signed [31:0] y);
            fit_result_t e;
            if (pending.size() == 0)
                report($sformatf("unexpected result status %0d", st));
            else
            begin
                e = pending.pop_front();
                if (st !== e.status)
                    report($sformatf("status %0d, expected %0d", st, e.status));
                if (x !== e.x)
                    report($sformatf("out_x %0d, expected %0d", x, e.x));
                if (y !== e.y)
                    report($sformatf("out_y %0d, expected %0d", y, e.y));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    bit          steady;
    bit          hold_req;
    int          cycles;

    vpfn_in_if  in_ch ();
    vpfn_out_if out_ch ();

    fit_scoreboard board = new();

    vector_point_fit_normalizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[vector_point_fit_normalizer] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check(out_ch.status, out_ch.out_x, out_ch.out_y);

    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 0;
                repeat (300) @(posedge clk);
                hold_req = 0;
            end
            else
                out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
        end
    end

    task automatic send_item(logic [1:0] c, logic [31:0] x, logic [31:0] y);
        if (!steady && $urandom_range(99) < 27)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_ch.valid   <= 1;
        in_ch.command <= c;
        in_ch.point_x <= x;
        in_ch.point_y <= y;
        do @(posedge clk); while (!in_ch.ready);
        board.note(c, x, y);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        board.write_reg(idx, d);
    endtask

    task automatic end_writes();
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] coord(int unsigned span);
        if ($urandom_range(15) == 0)
            return $urandom();
        return 32'(longint'($urandom_range(2 * span)) - longint'(span));
    endfunction

    task automatic random_phase(int n, bit hold);
        logic [1:0]  m;
        logic [31:0] iw, ih, base_x, base_y;
        int unsigned span;
        int          k;
        bit          framed;
        drain();
        m = $urandom_range(3);
        span = ($urandom_range(7) == 0) ? 32'h4000_0000 : (32'd1 << $urandom_range(26, 12));
        case ($urandom_range(5))
            0: iw = 0;
            1: iw = 32'hFFFF_FFFF;
            default: iw = $urandom_range(span, 1) | ($urandom() & 32'h8000_0000);
        endcase
        ih = ($urandom_range(5) == 0) ? 32'd0 : ($urandom_range(span, 1) | ($urandom() & 32'h8000_0000));
        write_reg(REG_FIT_MODE, ($urandom() & 32'hFFFF_FFFC) | 32'(m));
        write_reg(REG_IMG_WIDTH, iw);
        write_reg(REG_IMG_HEIGHT, ih);
        write_reg(REG_USE_FIXED, ($urandom_range(3) == 0) ? 32'd1 : 32'd0);
        base_x = coord(span);
        base_y = coord(span);
        write_reg(REG_FIX_MIN_X, base_x);
        write_reg(REG_FIX_MAX_X, ($urandom_range(9) == 0) ? base_x : coord(span));
        write_reg(REG_FIX_MIN_Y, base_y);
        write_reg(REG_FIX_MAX_Y, ($urandom_range(9) == 0) ? base_y : coord(span));
        end_writes();
        if (hold)
            hold_req = 1;
        framed = (m == MODE_FRAME) && ($urandom_range(3) != 0) && iw[30:0] != 0 && ih[30:0] != 0;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(9) == 0)
                send_item(2'($urandom_range(3)), $urandom(), $urandom());
            else if (k == 0 || $urandom_range(11) == 0)
                send_item(CMD_CLEAR, $urandom(), $urandom());
            else if (k < 5 || $urandom_range(5) == 0)
                send_item(CMD_MEASURE,
                          framed ? $urandom_range(iw[30:0]) : coord(span),
                          framed ? $urandom_range(ih[30:0]) : coord(span));
            else
                send_item(CMD_TRANSFORM, coord(span), coord(span));
            k++;
        end
    endtask

    initial
    begin
        rst_n         = 0;
        cfg_we        = 0;
        cfg_index     = REG_FIT_MODE;
        cfg_data      = 0;
        in_ch.valid   = 0;
        in_ch.command = CMD_CLEAR;
        in_ch.point_x = 0;
        in_ch.point_y = 0;
        steady        = 0;
        hold_req      = 0;
        cycles        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_item(CMD_TRANSFORM, 32'd5, 32'd5);
        send_item(2'd3, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(CMD_MEASURE, 32'd0, 32'd0);
        send_item(CMD_TRANSFORM, 32'd0, 32'd0);
        send_item(CMD_MEASURE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(CMD_MEASURE, 32'h8000_0000, 32'h8000_0000);
        send_item(CMD_TRANSFORM, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(CMD_TRANSFORM, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(CMD_CLEAR, 32'd0, 32'd0);
        send_item(CMD_MEASURE, 32'h0001_0000, 32'h0002_0000);
        send_item(CMD_MEASURE, 32'h0041_0000, 32'h0012_0000);
        send_item(CMD_TRANSFORM, 32'h0021_0000, 32'h000A_0000);
        drain();
        write_reg(REG_FIT_MODE, 32'(MODE_MAX));
        end_writes();
        send_item(CMD_TRANSFORM, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();
        write_reg(REG_FIT_MODE, 32'(MODE_FRAME));
        end_writes();
        send_item(CMD_TRANSFORM, 32'h0001_0000, 32'h0001_0000);
        drain();
        write_reg(REG_IMG_WIDTH, 32'h7FFF_FFFF);
        write_reg(REG_IMG_HEIGHT, 32'h0064_0000);
        end_writes();
        send_item(CMD_TRANSFORM, 32'h0030_0000, 32'h0030_0000);
        drain();
        write_reg(REG_FIT_MODE, 32'(MODE_DEV));
        end_writes();
        send_item(CMD_TRANSFORM, 32'h0030_0000, 32'h0030_0000);
        drain();
        write_reg(REG_USE_FIXED, 32'd1);
        write_reg(REG_FIX_MIN_X, 32'h7FFF_FFFF);
        write_reg(REG_FIX_MAX_X, 32'h8000_0000);
        write_reg(REG_FIX_MIN_Y, 32'h0010_0000);
        write_reg(REG_FIX_MAX_Y, 32'h0000_0000);
        write_reg(REG_FIT_MODE, 32'(MODE_PLAIN));
        end_writes();
        send_item(CMD_MEASURE, 32'h1234_5678, 32'h8765_4321);
        send_item(CMD_TRANSFORM, 32'h0000_0000, 32'hFFFF_0000);
        send_item(CMD_TRANSFORM, 32'h8000_0000, 32'h7FFF_FFFF);

        for (int p = 0; p < 40; p++)
        begin
            steady = (p >= 20 && p < 25);
            random_phase(20, p == 12);
            if (p == 8)
            begin
                drain();
                send_item(CMD_TRANSFORM, $urandom(), $urandom());
            end
        end

        drain();
        repeat (80) @(posedge clk);
        if (board.errors == 0)
            $display("[vector_point_fit_normalizer] OK");
        else
            $display("[vector_point_fit_normalizer] ERROR");
        $finish;
    end

endmodule
